FILE: hdl/window_convergence_detector_unit_defines.svh
// ---------------------------------------------------------------------------
// window_convergence_detector_unit_defines
// Assertion macros shared by the convergence detector RTL.
// ---------------------------------------------------------------------------
`ifndef WINDOW_CONVERGENCE_DETECTOR_UNIT_DEFINES_SVH
`define WINDOW_CONVERGENCE_DETECTOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define WCD_ASSERT_IMPL(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("window convergence detector check failed");

// Next-cycle implication.
`define WCD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("window convergence detector check failed");

`else

`define WCD_ASSERT_IMPL(label, clk, rst, cond, expr)
`define WCD_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

FILE: hdl/wcd_pkg.sv
// ---------------------------------------------------------------------------
// wcd_pkg
// Types and constants of the window convergence detector.
// ---------------------------------------------------------------------------
package wcd_pkg;

   localparam int WINDOW_MAX_DEF = 16;
   localparam int COUNT_BITS_DEF = 20;

   localparam int ERR_SUM_BITS   = 40;
   localparam int MEAN_BITS      = 32;
   localparam int EPS_BITS       = 16;
   localparam int FRAC_BITS      = 16;
   localparam int WSIZE_BITS     = 5;
   localparam int CSR_IDX_BITS   = 3;

   // Divider retires two quotient bits per cycle.
   localparam int DIV_RADIX_BITS = 2;
   localparam int DIV_STEPS      = ERR_SUM_BITS / DIV_RADIX_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_SIZE   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CORR_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INLIER_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUTLIER_LIMIT = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ERROR_EPS     = 3'd4;

   localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 5'd5;
   localparam logic [EPS_BITS-1:0]   EPS_RESET   = 16'd66;

   typedef logic [ERR_SUM_BITS-1:0] err_sum_type;
   typedef logic [MEAN_BITS-1:0]    mean_type;

endpackage

FILE: hdl/wcd_if.sv
// ---------------------------------------------------------------------------
// wcd_if
// Request and response channels of the window convergence detector.
// ---------------------------------------------------------------------------
interface wcd_req_if #(
   parameter int COUNT_BITS = wcd_pkg::COUNT_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   restart;
   logic [COUNT_BITS-1:0]  corr_count;
   logic [COUNT_BITS-1:0]  inlier_count;
   logic [COUNT_BITS-1:0]  outlier_count;
   wcd_pkg::err_sum_type   inlier_error_sum;

   modport source (
      output valid, restart, corr_count, inlier_count, outlier_count, inlier_error_sum,
      input  ready
   );
   modport sink (
      input  valid, restart, corr_count, inlier_count, outlier_count, inlier_error_sum,
      output ready
   );
endinterface

interface wcd_rsp_if;
   logic valid;
   logic ready;
   logic stop;
   logic sample_taken;

   modport source (output valid, stop, sample_taken, input ready);
   modport sink   (input  valid, stop, sample_taken, output ready);
endinterface

FILE: hdl/wcd_ram.sv
// ---------------------------------------------------------------------------
// wcd_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module wcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/window_convergence_detector_unit.sv
// Items with zero inliers skip the divider and go straight to the finish state.
// Other items run the radix-4 divider and write one row; a window that is not yet full
// answers after the write, a full one after a scan of W rows (W = effective window)
// through the single read port of the sample RAM, then drain, multiply and compare.
// A new request is taken only in the idle state, once the last item is finished.
// Reset clears control state, slot and fill count; RAM contents stay undefined.
// ---------------------------------------------------------------------------
// window_convergence_detector_unit
// Sliding-window convergence test over solver iteration statistics.
// ---------------------------------------------------------------------------
`include "window_convergence_detector_unit_defines.svh"

module window_convergence_detector_unit #(
   parameter int  WINDOW_MAX    = wcd_pkg::WINDOW_MAX_DEF,
   parameter int  COUNT_BITS    = wcd_pkg::COUNT_BITS_DEF,
   localparam int CSR_DATA_BITS =
      (COUNT_BITS > wcd_pkg::EPS_BITS) ? COUNT_BITS : wcd_pkg::EPS_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   wcd_req_if.sink                           req_chan,
   wcd_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [wcd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]          csr_wdata
);

   import wcd_pkg::*;

   // RAM address and fill count widths
   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int FW = $clog2(WINDOW_MAX + 1);
   localparam int CB = COUNT_BITS;
   // One RAM row: {corr, inlier, outlier, mean error}
   localparam int ROW_BITS = 3 * CB + MEAN_BITS;
   localparam int PROD_BITS = EPS_BITS + MEAN_BITS;

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_WRITE  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_MULT   = 3'd5;
   localparam logic [2:0] ST_CMP    = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [WSIZE_BITS-1:0] wsize_ff;
   logic [CB-1:0]         corr_lim_ff;
   logic [CB-1:0]         inl_lim_ff;
   logic [CB-1:0]         outl_lim_ff;
   logic [EPS_BITS-1:0]   eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff    <= WSIZE_RESET;
         corr_lim_ff <= '0;
         inl_lim_ff  <= '0;
         outl_lim_ff <= '0;
         eps_ff      <= EPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE:   wsize_ff    <= csr_wdata[WSIZE_BITS-1:0];
            CSR_CORR_LIMIT:    corr_lim_ff <= csr_wdata[CB-1:0];
            CSR_INLIER_LIMIT:  inl_lim_ff  <= csr_wdata[CB-1:0];
            CSR_OUTLIER_LIMIT: outl_lim_ff <= csr_wdata[CB-1:0];
            CSR_ERROR_EPS:     eps_ff      <= csr_wdata[EPS_BITS-1:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // Effective window: zero counts as one, saturate at the RAM depth.
   logic [FW-1:0] w_eff;
   always_comb begin
      if (wsize_ff == '0) begin
         w_eff = FW'(1);
      end else if (32'(wsize_ff) > WINDOW_MAX) begin
         w_eff = FW'(WINDOW_MAX);
      end else begin
         w_eff = FW'(wsize_ff);
      end
   end

   // ------------------------------------------------------------------
   // Control and item registers
   // ------------------------------------------------------------------
   logic [2:0]            state_ff, state_in;
   logic [AW-1:0]         slot_ff;
   logic [FW-1:0]         fill_ff;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff;
   logic [FW-1:0]         scan_cnt_ff;
   logic [AW-1:0]         scan_addr_ff;
   logic                  rd_valid_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_stop_ff;
   logic                  rsp_taken_ff;
   logic                  res_stop_ff;
   logic                  res_taken_ff;

   logic [CB-1:0]         corr_ff;
   logic [CB-1:0]         outl_ff;
   logic [CB-1:0]         div_ff;     // inlier count, also the divisor
   logic [CB-1:0]         rem_ff, rem_in;
   err_sum_type           quo_ff, quo_in;

   logic [CB-1:0]         c_lo_ff, c_hi_ff;
   logic [CB-1:0]         i_lo_ff, i_hi_ff;
   logic [CB-1:0]         o_lo_ff, o_hi_ff;
   mean_type              e_lo_ff, e_hi_ff;
   logic                  counts_ok_ff;
   mean_type              erange_ff;
   logic [PROD_BITS-1:0]  prod_ff;

   logic req_fire;
   logic out_free;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);

   // ------------------------------------------------------------------
   // Restoring divider, two quotient bits per cycle.
   // Dividend shifts out of quo on top while quotient bits enter below.
   // ------------------------------------------------------------------
   function automatic logic [CB+ERR_SUM_BITS-1:0] div_step(
      input logic [CB-1:0]  rem,
      input err_sum_type    quo,
      input logic [CB-1:0]  dvs
   );
      logic [CB:0] trial;
      logic [CB:0] diff;
      trial = {rem, quo[ERR_SUM_BITS-1]};
      diff  = trial - {1'b0, dvs};
      if (trial >= {1'b0, dvs}) begin
         return {diff[CB-1:0], quo[ERR_SUM_BITS-2:0], 1'b1};
      end
      return {trial[CB-1:0], quo[ERR_SUM_BITS-2:0], 1'b0};
   endfunction

   logic [CB-1:0] rem_mid;
   err_sum_type   quo_mid;
   always_comb begin
      {rem_mid, quo_mid} = div_step(rem_ff, quo_ff, div_ff);
      {rem_in, quo_in}   = div_step(rem_mid, quo_mid, div_ff);
   end

   // Mean error in Q16.16, saturated when the quotient overflows 32 bits.
   mean_type mean_sat;
   assign mean_sat = (quo_ff[ERR_SUM_BITS-1:MEAN_BITS] != '0) ? '1 : quo_ff[MEAN_BITS-1:0];

   // ------------------------------------------------------------------
   // Sample RAM: write once per item that has inliers, then scan back over a full window.
   // ------------------------------------------------------------------
   logic                ram_we;
   logic [ROW_BITS-1:0] ram_wdata;
   logic [ROW_BITS-1:0] ram_rdata;

   assign ram_we    = (state_ff == ST_WRITE);
   assign ram_wdata = {corr_ff, div_ff, outl_ff, mean_sat};

   wcd_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (ram_wdata),
      .rd_addr (scan_addr_ff),
      .rd_data (ram_rdata)
   );

   logic [CB-1:0] rd_corr, rd_inl, rd_outl;
   mean_type      rd_mean;
   assign {rd_corr, rd_inl, rd_outl, rd_mean} = ram_rdata;

   logic [FW-1:0] fill_inc;
   logic          win_full;
   assign fill_inc = (32'(fill_ff) < WINDOW_MAX) ? fill_ff + 1'b1 : fill_ff;
   assign win_full = (fill_inc >= w_eff);

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_chan.inlier_count == '0) ? ST_FINISH : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE:  state_in = win_full ? ST_SCAN : ST_FINISH;
         ST_SCAN: begin
            if (scan_cnt_ff == w_eff - 1'b1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_MULT;
         ST_MULT:   state_in = ST_CMP;
         ST_CMP:    state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == ST_SCAN);

         // Restart empties the window before the item counts.
         if (req_fire && req_chan.restart) begin
            slot_ff <= '0;
            fill_ff <= '0;
         end else if (state_ff == ST_WRITE) begin
            slot_ff <= (slot_ff == AW'(WINDOW_MAX - 1)) ? '0 : slot_ff + 1'b1;
            fill_ff <= fill_inc;
         end

         // Hold the response until taken, then load the next one.
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               corr_ff      <= req_chan.corr_count;
               outl_ff      <= req_chan.outlier_count;
               div_ff       <= req_chan.inlier_count;
               rem_ff       <= '0;
               quo_ff       <= req_chan.inlier_error_sum;
               div_cnt_ff   <= '0;
               res_stop_ff  <= 1'b0;
               res_taken_ff <= (req_chan.inlier_count != '0);
            end
         end
         ST_DIV: begin
            rem_ff     <= rem_in;
            quo_ff     <= quo_in;
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         ST_WRITE: begin
            // Start the scan at the slot just written and walk backward.
            scan_addr_ff <= slot_ff;
            scan_cnt_ff  <= '0;
            c_lo_ff <= '1;  c_hi_ff <= '0;
            i_lo_ff <= '1;  i_hi_ff <= '0;
            o_lo_ff <= '1;  o_hi_ff <= '0;
            e_lo_ff <= '1;  e_hi_ff <= '0;
         end
         ST_SCAN: begin
            scan_addr_ff <= (scan_addr_ff == '0) ? AW'(WINDOW_MAX - 1) : scan_addr_ff - 1'b1;
            scan_cnt_ff  <= scan_cnt_ff + 1'b1;
         end
         ST_MULT: begin
            counts_ok_ff <= (c_hi_ff - c_lo_ff <= corr_lim_ff)
                         && (i_hi_ff - i_lo_ff <= inl_lim_ff)
                         && (o_hi_ff - o_lo_ff <= outl_lim_ff);
            erange_ff    <= e_hi_ff - e_lo_ff;
            prod_ff      <= PROD_BITS'(eps_ff) * PROD_BITS'(e_hi_ff);
         end
         ST_CMP: begin
            // Relative spread: range * 2^16 against epsilon * max.
            res_stop_ff <= counts_ok_ff && ({erange_ff, FRAC_BITS'(0)} <= prod_ff);
         end
         default: ;
      endcase

      // Fold RAM read data into the running extremes.
      if (rd_valid_ff) begin
         if (rd_corr < c_lo_ff) c_lo_ff <= rd_corr;
         if (rd_corr > c_hi_ff) c_hi_ff <= rd_corr;
         if (rd_inl  < i_lo_ff) i_lo_ff <= rd_inl;
         if (rd_inl  > i_hi_ff) i_hi_ff <= rd_inl;
         if (rd_outl < o_lo_ff) o_lo_ff <= rd_outl;
         if (rd_outl > o_hi_ff) o_hi_ff <= rd_outl;
         if (rd_mean < e_lo_ff) e_lo_ff <= rd_mean;
         if (rd_mean > e_hi_ff) e_hi_ff <= rd_mean;
      end

      if (state_ff == ST_FINISH && out_free) begin
         rsp_stop_ff  <= res_stop_ff;
         rsp_taken_ff <= res_taken_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.stop         = rsp_stop_ff;
   assign rsp_chan.sample_taken = rsp_taken_ff;

   // A scan only runs on a full window.
   logic win_full_hold_ok;
   assign win_full_hold_ok = (fill_ff >= w_eff);

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `WCD_ASSERT_NEXT(a_zero_inlier_skip, clock, reset,
      req_fire && req_chan.inlier_count == '0, state_ff == ST_FINISH)
   `WCD_ASSERT_IMPL(a_stop_needs_sample, clock, reset,
      rsp_chan.valid && rsp_chan.stop, rsp_chan.sample_taken)
   `WCD_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, 32'(fill_ff) <= WINDOW_MAX)
   `WCD_ASSERT_IMPL(a_scan_in_window, clock, reset,
      state_ff == ST_SCAN, scan_cnt_ff < w_eff && win_full_hold_ok)

endmodule
